FILE: hdl/crsf_pkg.sv
package crsf_pkg;

   // Frame store geometry
   localparam int FRAME_DEPTH = 64;
   localparam int ADDR_W      = $clog2(FRAME_DEPTH);

   localparam int CHANNEL_COUNT = 16;
   localparam int CH_W          = $clog2(CHANNEL_COUNT);

   // Command from the byte parser to the result unpacker
   typedef struct packed {
      logic go;     // a good frame has just completed
      logic stats;  // 1 = link statistics, 0 = channel frame
   } start_type;

endpackage

FILE: hdl/crsf_ram.sv
module crsf_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/crsf_parse.sv
module crsf_parse (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              rx_byte,
   output logic                    wr_en,
   output logic [crsf_pkg::ADDR_W-1:0] wr_addr,
   output logic [7:0]              wr_data,
   output crsf_pkg::start_type     start
);

   import crsf_pkg::*;

   localparam logic [7:0] SYNC_BYTE  = 8'hC8;
   localparam logic [7:0] CRC_POLY   = 8'hD5;
   localparam logic [7:0] MIN_LEN    = 8'd4;
   localparam logic [7:0] MAX_LEN    = 8'd64;
   localparam logic [7:0] TYPE_RC    = 8'h16;
   localparam logic [7:0] TYPE_LINK  = 8'h14;
   localparam logic [6:0] LEN_RC     = 7'd24;
   localparam logic [6:0] LEN_LINK   = 7'd12;

   typedef enum logic [1:0] {
      P_SYNC,
      P_LEN,
      P_DATA
   } phase_type;

   phase_type  phase_ff;
   logic [6:0] len_ff;
   logic [6:0] pos_ff;
   logic [7:0] crc_ff;
   logic [7:0] type_ff;

   logic [6:0] pos_in;
   logic       at_end;
   logic       crc_ok;
   logic       is_rc;
   logic       is_link;
   logic [7:0] crc_in;

   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   assign pos_in  = pos_ff + 7'd1;
   assign at_end  = (pos_in >= len_ff);
   assign crc_ok  = (crc_ff == rx_byte);
   assign is_rc   = (type_ff == TYPE_RC) && (len_ff == LEN_RC);
   assign is_link = (type_ff == TYPE_LINK) && (len_ff == LEN_LINK);
   assign crc_in  = crc_step(crc_ff, rx_byte);

   // Store every data byte, the CRC byte included
   assign wr_en   = accept && (phase_ff == P_DATA) && (32'(pos_ff) < FRAME_DEPTH);
   assign wr_addr = ADDR_W'(pos_ff);
   assign wr_data = rx_byte;

   assign start.go    = accept && (phase_ff == P_DATA) && at_end && crc_ok
                        && (is_rc || is_link);
   assign start.stats = is_link;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_SYNC;
         len_ff   <= '0;
         pos_ff   <= '0;
         crc_ff   <= '0;
      end else if (accept) begin
         case (phase_ff)
            P_SYNC: begin
               if (rx_byte == SYNC_BYTE) begin
                  phase_ff <= P_LEN;
               end
            end
            P_LEN: begin
               if (rx_byte >= MIN_LEN && rx_byte <= MAX_LEN) begin
                  len_ff   <= rx_byte[6:0];
                  pos_ff   <= '0;
                  crc_ff   <= '0;
                  phase_ff <= P_DATA;
               end else begin
                  phase_ff <= P_SYNC;
               end
            end
            P_DATA: begin
               pos_ff <= pos_in;
               if (pos_ff == '0) begin
                  type_ff <= rx_byte;
               end
               if (at_end) begin
                  phase_ff <= P_SYNC;
               end else begin
                  crc_ff <= crc_in;
               end
            end
            default: begin
               phase_ff <= P_SYNC;
            end
         endcase
      end
   end

endmodule

FILE: hdl/crsf_unpack.sv
module crsf_unpack (
   input  logic                        clock,
   input  logic                        reset,
   input  crsf_pkg::start_type         start,
   output logic                        busy,
   output logic [crsf_pkg::ADDR_W-1:0] rd_addr,
   input  logic [7:0]                  rd_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_frame_kind,
   output logic [3:0]                  rsp_channel_index,
   output logic [10:0]                 rsp_pulse_width,
   output logic [7:0]                  rsp_link_quality,
   output logic signed [7:0]           rsp_rssi_dbm,
   output logic                        rsp_last
);

   import crsf_pkg::*;

   localparam logic [10:0] RAW_MASK    = 11'h7FF;
   localparam logic [10:0] RAW_MIN     = 11'd172;
   localparam logic [10:0] RAW_MAX     = 11'd1811;
   localparam logic [10:0] PULSE_BASE  = 11'd988;
   // 1024/1639 as (d * SCALE_RECIP) >> 22, exact for d up to 1639
   localparam logic [21:0] SCALE_RECIP = 22'd2620481;
   localparam int          SCALE_SHIFT = 22;
   localparam logic [ADDR_W-1:0] LQ_ADDR   = ADDR_W'(3);
   localparam logic [ADDR_W-1:0] RSSI_ADDR = ADDR_W'(1);

   typedef enum logic [1:0] {
      U_IDLE,
      U_FETCH,
      U_MUL,
      U_OUT
   } ustate_type;

   ustate_type        state_ff;
   logic              stats_ff;
   logic [CH_W-1:0]   ch_ff;
   logic [1:0]        step_ff;
   logic [23:0]       word_ff;
   logic [32:0]       prod_ff;

   logic              valid_ff;
   logic              kind_ff;
   logic [3:0]        chan_ff;
   logic [10:0]       pulse_ff;
   logic [7:0]        lq_ff;
   logic [7:0]        rssi_ff;
   logic              last_ff;

   logic [7:0]        bit_pos;
   logic [23:0]       shifted;
   logic [10:0]       raw;
   logic [10:0]       clamped;
   logic [10:0]       delta;
   logic [32:0]       prod_in;
   logic [1:0]        last_step;
   logic              out_free;
   logic              final_rsp;
   logic              load_rsp;

   assign bit_pos   = 8'(ch_ff) * 8'd11;
   assign shifted   = word_ff >> bit_pos[2:0];
   assign raw       = shifted[10:0] & RAW_MASK;
   assign clamped   = (raw < RAW_MIN) ? RAW_MIN : ((raw > RAW_MAX) ? RAW_MAX : raw);
   assign delta     = clamped - RAW_MIN;
   assign prod_in   = 33'(delta) * 33'(SCALE_RECIP);
   assign last_step = stats_ff ? 2'd2 : 2'd3;
   assign out_free  = !valid_ff || !rsp_stall;
   assign final_rsp = stats_ff || (ch_ff == CH_W'(CHANNEL_COUNT - 1));
   assign load_rsp  = (state_ff == U_OUT) && out_free;

   always_comb begin
      if (stats_ff) begin
         rd_addr = (step_ff == 2'd0) ? RSSI_ADDR : LQ_ADDR;
      end else begin
         rd_addr = ADDR_W'(bit_pos[7:3]) + ADDR_W'(1) + ADDR_W'(step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         valid_ff <= 1'b0;
      end else begin
         // load a new response, else drain the output register once taken
         if (load_rsp) begin
            valid_ff <= 1'b1;
         end else if (valid_ff && !rsp_stall) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            U_IDLE: begin
               if (start.go) begin
                  stats_ff <= start.stats;
                  ch_ff    <= '0;
                  step_ff  <= '0;
                  state_ff <= U_FETCH;
               end
            end
            U_FETCH: begin
               // read data comes back registered, in the cycle after its address
               case (step_ff)
                  2'd1:    word_ff[7:0]   <= rd_data;
                  2'd2:    word_ff[15:8]  <= rd_data;
                  2'd3:    word_ff[23:16] <= rd_data;
                  default: ;
               endcase
               if (step_ff == last_step) begin
                  step_ff  <= '0;
                  state_ff <= stats_ff ? U_OUT : U_MUL;
               end else begin
                  step_ff <= step_ff + 2'd1;
               end
            end
            U_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= U_OUT;
            end
            U_OUT: begin
               if (out_free) begin
                  kind_ff  <= stats_ff;
                  last_ff  <= final_rsp;
                  if (stats_ff) begin
                     chan_ff  <= '0;
                     pulse_ff <= '0;
                     lq_ff    <= word_ff[15:8];
                     rssi_ff  <= ~word_ff[7:0] + 8'd1;
                  end else begin
                     chan_ff  <= 4'(ch_ff);
                     pulse_ff <= PULSE_BASE + prod_ff[SCALE_SHIFT +: 11];
                     lq_ff    <= '0;
                     rssi_ff  <= '0;
                  end
                  if (final_rsp) begin
                     state_ff <= U_IDLE;
                  end else begin
                     ch_ff    <= ch_ff + CH_W'(1);
                     state_ff <= U_FETCH;
                  end
               end
            end
            default: begin
               state_ff <= U_IDLE;
            end
         endcase
      end
   end

   assign busy              = (state_ff != U_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_frame_kind    = kind_ff;
   assign rsp_channel_index = chan_ff;
   assign rsp_pulse_width   = pulse_ff;
   assign rsp_link_quality  = lq_ff;
   assign rsp_rssi_dbm      = signed'(rssi_ff);
   assign rsp_last          = last_ff;

endmodule

FILE: hdl/crsf_frame_receiver.sv
// Serial RC frame receiver.
// Request channel (req_valid / req_stall / req_rx_byte): one received byte per
// request. While the block hunts for sync or stores a frame it takes one request
// every cycle; req_stall rises only while a finished frame is being unpacked.
// Response channel (rsp_valid / rsp_stall / rsp_*): one response per channel of
// an RC frame (16, the last with rsp_last set) or one link statistics response.
// After a channel frame's final byte the block builds 16 responses, each by
// fetch steps (three reads of the frame store's single read port), a multiply
// step and an output load; req_stall stays high throughout, and longer while
// rsp_stall holds a response. A statistics frame stalls requests for its fetch
// steps and one output load. The first response is registered after these
// steps: fetch, multiply and output load (RC) or fetch and output load (stats).
// The output register lets unpacking of the next channel overlap a stalled
// response; a held response keeps its payload until rsp_stall drops.
// Reset (synchronous) returns the parser to hunting and clears all pending
// responses; the frame store is not cleared, as a frame reads only what it wrote.
module crsf_frame_receiver (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_frame_kind,
   output logic [3:0]        rsp_channel_index,
   output logic [10:0]       rsp_pulse_width,
   output logic [7:0]        rsp_link_quality,
   output logic signed [7:0] rsp_rssi_dbm,
   output logic              rsp_last
);

   import crsf_pkg::*;

   logic              req_accept;
   logic              busy;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   start_type         start;

   // hold requests while a frame is unpacked
   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;

   // sync hunt, length check, byte storage and CRC
   crsf_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .start   (start)
   );

   // frame store: one write port for the parser, one read port for the unpacker
   crsf_ram #(
      .DEPTH (FRAME_DEPTH),
      .WIDTH (8)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read back the stored frame and build responses
   crsf_unpack u_unpack (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_kind    (rsp_frame_kind),
      .rsp_channel_index (rsp_channel_index),
      .rsp_pulse_width   (rsp_pulse_width),
      .rsp_link_quality  (rsp_link_quality),
      .rsp_rssi_dbm      (rsp_rssi_dbm),
      .rsp_last          (rsp_last)
   );

`ifndef SYNTHESIS
   // channel pulses always lie in the scaled range
   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_kind) |->
         (rsp_pulse_width >= 11'd988 && rsp_pulse_width <= 11'd2012))
      else $error("channel pulse out of range");

   // a statistics response is always the only one of its frame
   a_stats_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_kind) |-> (rsp_last && rsp_channel_index == 4'd0))
      else $error("statistics response malformed");

   // the final channel response carries the top channel number
   a_rc_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_kind) |-> (rsp_last == (rsp_channel_index == 4'd15)))
      else $error("rsp_last out of step with channel index");

   // no new frame can complete while responses are still being built
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      busy |-> !start.go)
      else $error("frame completed while unpacker busy");
`endif

endmodule
